>>> rtl/prs_pkg.sv
`default_nettype none
package prs_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 80;
    localparam int RC_W    = 5;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [RC_W-1:0]    t_round;

    // configuration register indexes
    typedef enum logic [7:0] {
        CFG_KEY_LOW  = 8'd0,
        CFG_KEY_HIGH = 8'd1
    } t_cfg_index;

    // one pipeline slot handed from cell to cell
    typedef struct packed {
        logic   valid;
        t_block state;
        t_key   key;
    } t_stage;

    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0:    y = 4'hC;
            4'h1:    y = 4'h5;
            4'h2:    y = 4'h6;
            4'h3:    y = 4'hB;
            4'h4:    y = 4'h9;
            4'h5:    y = 4'h0;
            4'h6:    y = 4'hA;
            4'h7:    y = 4'hD;
            4'h8:    y = 4'h3;
            4'h9:    y = 4'hE;
            4'hA:    y = 4'hF;
            4'hB:    y = 4'h8;
            4'hC:    y = 4'h4;
            4'hD:    y = 4'h7;
            4'hE:    y = 4'h1;
            4'hF:    y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic t_block nibble_sub_layer(input t_block x);
        t_block y;
        for (int n = 0; n < BLOCK_W / 4; n++) begin
            y[4*n +: 4] = sbox(x[4*n +: 4]);
        end
        return y;
    endfunction

    // bit i moves to i/4 + 16*(i mod 4)
    function automatic t_block bit_perm_layer(input t_block x);
        t_block y;
        for (int i = 0; i < BLOCK_W; i++) begin
            y[(i / 4) + 16 * (i % 4)] = x[i];
        end
        return y;
    endfunction

    function automatic t_block round_key(input t_key k);
        return k[KEY_W-1 -: BLOCK_W];
    endfunction

    // rotate right by 19, s-box on top nibble, round counter into bits 19..15
    function automatic t_key key_update(input t_key k, input t_round rc);
        t_key y;
        y = {k[18:0], k[KEY_W-1:19]};
        y[KEY_W-1 -: 4] = sbox(y[KEY_W-1 -: 4]);
        y[19:15] = y[19:15] ^ rc;
        return y;
    endfunction

endpackage
`default_nettype wire

>>> rtl/present80_encrypt.sv
// present80_encrypt: PRESENT-80 encryption, one 64-bit block per cycle unless stalled
//
// channels
//   input:  i_valid / o_ready carry i_plaintext; a transfer loads round cell 0
//   output: o_valid / i_ready carry o_ciphertext from the last round cell
//   config: i_cfg_valid / o_cfg_ready carry i_cfg_index and i_cfg_data;
//           index 0 writes key bits 63..0, index 1 writes key bits 79..64
//           (low 16 data bits), other indexes are ignored; always ready
// pipeline: an input transfer passes through the row of ROUNDS round cells
//   (ROUNDS is 31 by default); the final key xor sits on the output side
// throughput: one block per cycle unless the output stalls, set by the
//   row of ROUNDS round cells that all shift together
// stall: when o_valid is high and i_ready is low the whole row holds, so
//   o_ready drops and o_ciphertext stays put until the transfer
// reset: synchronous active-low i_rst_n empties every cell and clears the
//   key to zero; the block takes items in the first cycle after reset
// each block carries its own copy of the key down the row, so key writes
//   only affect blocks taken after the write
`default_nettype none
module present80_encrypt #(
    parameter int ROUNDS = 31
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // plaintext channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [63:0] i_plaintext,
    // ciphertext channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_ciphertext,
    // configuration channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    // key registers
    logic [63:0] r_key_low;
    logic [15:0] r_key_high;

    // slot entering each cell; slot ROUNDS is the last cell's output
    prs_pkg::t_stage w_stage [ROUNDS+1];
    logic            w_advance;
    logic            w_cfg_xfer;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (w_cfg_xfer) begin
            case (i_cfg_index)
                prs_pkg::CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                prs_pkg::CFG_KEY_HIGH: r_key_high <= i_cfg_data[15:0];
                default: ;  // unknown register, write dropped
            endcase
        end
    end

    // the row moves whenever the output slot is empty or being taken
    assign w_advance = i_ready || !w_stage[ROUNDS].valid;
    assign o_ready   = w_advance;

    // slot handed into the first cell; the key snapshot travels with it
    assign w_stage[0] = '{valid: i_valid,
                          state: i_plaintext,
                          key:   {r_key_high, r_key_low}};

    for (genvar g = 0; g < ROUNDS; g++) begin : g_cell
        prs_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (w_advance),
            .i_round   (prs_pkg::t_round'(g + 1)),
            .i_stage   (w_stage[g]),
            .o_stage   (w_stage[g+1])
        );
    end

    // final whitening with the last round key
    assign o_valid      = w_stage[ROUNDS].valid;
    assign o_ciphertext = w_stage[ROUNDS].state ^
                          prs_pkg::round_key(w_stage[ROUNDS].key);

    // input side takes a block exactly when the row shifts
    a_ready_follows_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready == (i_ready || !o_valid))
        else $error("input ready does not track output side");

    // an accepted block lands in the first cell
    a_accept_fills_cell0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> w_stage[1].valid)
        else $error("accepted block lost at first cell");

    // a stalled row keeps its output block
    a_stall_holds_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_ciphertext)))
        else $error("output block changed during stall");

    // key changes only through a configuration transfer
    a_key_only_by_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_cfg_xfer |=> ($stable(r_key_low) && $stable(r_key_high)))
        else $error("key changed without configuration transfer");

endmodule
`default_nettype wire

>>> rtl/prs_round_cell.sv
`default_nettype none
module prs_round_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_advance,
    input  wire prs_pkg::t_round i_round,
    input  wire prs_pkg::t_stage i_stage,
    output prs_pkg::t_stage      o_stage
);

    logic            r_valid;
    prs_pkg::t_block r_state;
    prs_pkg::t_key   r_key;
    prs_pkg::t_block n_state;
    prs_pkg::t_key   n_key;

    always_comb begin
        n_state = prs_pkg::bit_perm_layer(prs_pkg::nibble_sub_layer(
                      i_stage.state ^ prs_pkg::round_key(i_stage.key)));
        n_key   = prs_pkg::key_update(i_stage.key, i_round);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_stage = '{valid: r_valid, state: r_state, key: r_key};

endmodule
`default_nettype wire
